// ===== rtl/hla_pkg.sv =====
package hla_pkg;

  localparam int unsigned MAX_SIDE_DEF  = 512;
  localparam int unsigned RHO_BINS_DEF  = 1024;
  localparam int unsigned ANGLE_BINS    = 180;
  localparam int unsigned LAST_ANGLE    = 179;
  localparam int unsigned COUNT_WIDTH   = 16;
  localparam int unsigned ANGLE_W       = 8;
  localparam int unsigned FRAC_BITS     = 14;
  localparam logic [7:0]  WHITE         = 8'd255;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_VOTE  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  typedef struct packed {
    logic [1:0] op;
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] rho_index;
    logic [7:0] angle_index;
  } in_req_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] vote_count;
    logic                   read_valid;
  } out_rsp_t;

  localparam logic [15:0] QSIN [91] = '{
    16'd0, 16'd286, 16'd572, 16'd857, 16'd1143, 16'd1428, 16'd1713, 16'd1997, 16'd2280,
    16'd2563, 16'd2845, 16'd3126, 16'd3406, 16'd3686, 16'd3964, 16'd4240, 16'd4516,
    16'd4790, 16'd5063, 16'd5334, 16'd5604, 16'd5872, 16'd6138, 16'd6402, 16'd6664,
    16'd6924, 16'd7182, 16'd7438, 16'd7692, 16'd7943, 16'd8192, 16'd8438, 16'd8682,
    16'd8923, 16'd9162, 16'd9397, 16'd9630, 16'd9860, 16'd10087, 16'd10311, 16'd10531,
    16'd10749, 16'd10963, 16'd11174, 16'd11381, 16'd11585, 16'd11786, 16'd11982,
    16'd12176, 16'd12365, 16'd12551, 16'd12733, 16'd12911, 16'd13085, 16'd13255,
    16'd13421, 16'd13583, 16'd13741, 16'd13894, 16'd14044, 16'd14189, 16'd14330,
    16'd14466, 16'd14598, 16'd14726, 16'd14849, 16'd14968, 16'd15082, 16'd15191,
    16'd15296, 16'd15396, 16'd15491, 16'd15582, 16'd15668, 16'd15749, 16'd15826,
    16'd15897, 16'd15964, 16'd16026, 16'd16083, 16'd16135, 16'd16182, 16'd16225,
    16'd16262, 16'd16294, 16'd16322, 16'd16344, 16'd16362, 16'd16374, 16'd16382,
    16'd16384
  };

  function automatic logic signed [15:0] sine_q14(input logic [7:0] a);
    logic [7:0] k;
    k = (a <= 8'd90) ? a : 8'(8'd180 - a);
    return signed'(QSIN[k[6:0]]);
  endfunction

  function automatic logic signed [15:0] cosine_q14(input logic [7:0] a);
    logic [7:0] k;
    k = (a <= 8'd90) ? 8'(8'd90 - a) : 8'(a - 8'd90);
    return (a <= 8'd90) ? signed'(QSIN[k[6:0]]) : -signed'(QSIN[k[6:0]]);
  endfunction

endpackage

// ===== rtl/hla_store.sv =====
module hla_store #(
  parameter int unsigned AW = 18
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AW-1:0]                      waddr_i,
  input  logic [hla_pkg::COUNT_WIDTH-1:0]    wdata_i,
  input  logic [AW-1:0]                      raddr_i,
  output logic [hla_pkg::COUNT_WIDTH-1:0]    rdata_o
);

  logic [hla_pkg::COUNT_WIDTH-1:0] mem [2**AW];
  logic [hla_pkg::COUNT_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hough_line_accumulator_top.sv =====
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  in_req_i (op, pixel, color, read index)
// out       output     out_valid_o / out_ready_i out_rsp_o (vote_count, read_valid)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A white pixel inside the image issues its 180 angles one per cycle through the read port
// and the write port of the vote store; the pipeline then drains through its l1 and l2 stages,
// the result is handed over from the done state and the block returns to idle.
// A read goes through the read state; other pixels and unused codes go straight to done.
// A clear sweeps the store one entry per cycle over its whole address space,
// 2**$clog2(RHO_BINS) * 256 entries, then gives a result; the same sweep runs after reset,
// and no request is taken until it ends.
// One request is worked on at a time; a new one may be taken while a result waits.
module hough_line_accumulator_top #(
  parameter int unsigned MAX_SIDE = hla_pkg::MAX_SIDE_DEF,
  parameter int unsigned RHO_BINS = hla_pkg::RHO_BINS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hla_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hla_pkg::out_rsp_t out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [9:0]        cfg_data_i
);

  localparam int unsigned RHO_W = $clog2(RHO_BINS);
  localparam int unsigned AW    = RHO_W + hla_pkg::ANGLE_W;
  localparam int unsigned CW    = hla_pkg::COUNT_WIDTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_VOTE  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [9:0]    width_q, height_q;
  logic [AW-1:0] clr_q, clr_d;
  logic          clr_rsp_q, clr_rsp_d;
  logic [8:0]    x_q, x_d, y_q, y_d;
  logic [7:0]    ang_q, ang_d;
  logic          issue_q, issue_d;
  logic          rd_ok_q, rd_ok_d;
  hla_pkg::out_rsp_t res_q, res_d;
  logic          out_valid_q;
  hla_pkg::out_rsp_t out_q;

  logic                 l1_q, l2_q, ok2_q;
  logic [7:0]           a1_q;
  logic signed [25:0]   pc_q, ps_q;
  logic [AW-1:0]        addr2_q;

  logic [9:0]           w_eff, h_eff;
  logic [10:0]          span;
  logic signed [26:0]   sum;
  logic [10:0]          rho;
  logic                 ok1;
  logic [AW-1:0]        vaddr, raddr, waddr;
  logic                 we;
  logic [CW-1:0]        wdata, rdata;
  logic                 accept, out_free, white, in_image;

  assign w_eff  = (32'(width_q)  > MAX_SIDE) ? 10'(MAX_SIDE) : width_q;
  assign h_eff  = (32'(height_q) > MAX_SIDE) ? 10'(MAX_SIDE) : height_q;
  assign span   = 11'(w_eff) + 11'(h_eff);
  assign accept = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign white  = (in_req_i.red == hla_pkg::WHITE) && (in_req_i.green == hla_pkg::WHITE)
                  && (in_req_i.blue == hla_pkg::WHITE);
  assign in_image = (10'(in_req_i.pixel_x) < w_eff) && (10'(in_req_i.pixel_y) < h_eff);

  assign sum   = 27'(pc_q) + 27'(ps_q);
  assign rho   = sum[24:14];
  assign ok1   = !sum[26] && (rho < span) && (32'(rho) < RHO_BINS);
  assign vaddr = {RHO_W'(rho), a1_q};
  assign raddr = (state_q == S_IDLE) ?
                 {RHO_W'(in_req_i.rho_index), in_req_i.angle_index} : vaddr;

  always_comb begin
    we    = 1'b0;
    waddr = addr2_q;
    wdata = (rdata == {CW{1'b1}}) ? rdata : CW'(rdata + 1'b1);
    if (state_q == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (l2_q && ok2_q) begin
      we = 1'b1;
    end
  end

  hla_store #(.AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    clr_rsp_d = clr_rsp_q;
    x_d       = x_q;
    y_d       = y_q;
    ang_d     = ang_q;
    issue_d   = issue_q;
    rd_ok_d   = rd_ok_q;
    res_d     = res_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          x_d   = in_req_i.pixel_x;
          y_d   = in_req_i.pixel_y;
          case (in_req_i.op)
            hla_pkg::OP_CLEAR: begin
              state_d   = S_CLEAR;
              clr_d     = '0;
              clr_rsp_d = 1'b1;
            end
            hla_pkg::OP_VOTE: begin
              if (white && in_image) begin
                state_d = S_VOTE;
                ang_d   = '0;
                issue_d = 1'b1;
              end else begin
                state_d = S_DONE;
              end
            end
            hla_pkg::OP_READ: begin
              state_d = S_READ;
              rd_ok_d = (32'(in_req_i.rho_index) < RHO_BINS) &&
                        (32'(in_req_i.angle_index) < hla_pkg::ANGLE_BINS);
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        clr_d = AW'(clr_q + 1'b1);
        if (clr_q == {AW{1'b1}}) begin
          state_d = clr_rsp_q ? S_DONE : S_IDLE;
        end
      end
      S_VOTE: begin
        if (issue_q) begin
          if (32'(ang_q) == hla_pkg::LAST_ANGLE) begin
            issue_d = 1'b0;
          end
          ang_d = 8'(ang_q + 1'b1);
        end else if (!l1_q && !l2_q) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        res_d.read_valid = rd_ok_q;
        res_d.vote_count = rd_ok_q ? rdata : '0;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      clr_rsp_q   <= 1'b0;
      issue_q     <= 1'b0;
      ang_q       <= '0;
      l1_q        <= 1'b0;
      l2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      width_q     <= 10'd512;
      height_q    <= 10'd512;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_rsp_q <= (state_q == S_CLEAR && state_d != S_CLEAR) ? 1'b0 : clr_rsp_d;
      issue_q   <= issue_d;
      ang_q     <= ang_d;
      l1_q      <= issue_q && (state_q == S_VOTE);
      l2_q      <= l1_q;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          hla_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          hla_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    rd_ok_q <= rd_ok_d;
    res_q   <= res_d;
    a1_q    <= ang_q;
    pc_q    <= signed'({1'b0, x_q}) * hla_pkg::cosine_q14(ang_q);
    ps_q    <= signed'({1'b0, y_q}) * hla_pkg::sine_q14(ang_q);
    ok2_q   <= ok1;
    addr2_q <= vaddr;
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign cfg_ready_o = 1'b1;

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_CLEAR) || (state_q == S_VOTE))
    else $error("store written outside a clear or a vote");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q |-> (32'(ang_q) <= hla_pkg::LAST_ANGLE))
    else $error("angle counter past last angle");

  a_vote_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l2_q && ok2_q && state_q == S_VOTE) |-> (wdata != '0))
    else $error("vote wrote a zero count");

  a_vote_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_VOTE && state_q != S_VOTE) |-> (!l1_q && !l2_q))
    else $error("vote left with pipeline busy");

endmodule
